/* hdl/pphash_pkg.sv */
// ----------------------------------------------------------------------------
// pphash_pkg
// Shared types and constants for the prefix polynomial hash table: the
// prime, the Barrett reduction constant, operation and status codes, and
// the control sequencer states.
// ----------------------------------------------------------------------------
package pphash_pkg;

  // Hash words are residues modulo a 30-bit prime
  localparam int          HASH_W     = 30;
  localparam logic [29:0] HASH_PRIME = 30'd1000000007;

  // floor(2^60 / HASH_PRIME), Barrett constant for 60-bit products
  localparam logic [30:0] BARRETT_M  = 31'd1152921496;

  // Default string capacity and base after reset
  localparam int          DEF_MAX_LEN = 1024;
  localparam logic [29:0] BASE_RESET  = 30'd255;

  // Register stages of the modular multiplier
  localparam int          MM_LAT = 5;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_QUERY  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BEYOND = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MUL,
    S_FIN,
    S_DONE
  } state_t;

endpackage

/* hdl/pphash_modmul.sv */
// ----------------------------------------------------------------------------
// pphash_modmul
// Pipelined modular multiplier: r = (a * b) mod HASH_PRIME for operands
// below the prime. Five register stages: product, Barrett quotient,
// quotient times prime, raw remainder, final correction.
// ----------------------------------------------------------------------------
module pphash_modmul (
  input  logic                          clk,
  input  logic [pphash_pkg::HASH_W-1:0] a,
  input  logic [pphash_pkg::HASH_W-1:0] b,
  output logic [pphash_pkg::HASH_W-1:0] r
);
  import pphash_pkg::*;

  logic [59:0] prod;
  logic [61:0] quot_prod;
  logic [31:0] prod_lo2;
  logic [31:0] qp_lo;
  logic [31:0] prod_lo3;
  logic [31:0] rem_raw;
  logic [29:0] rem;

  logic [30:0] quot_est;
  logic [30:0] quot;
  logic [31:0] rem_m1;
  logic [31:0] rem_m2;

  localparam logic [31:0] PRIME_32  = {2'b00, HASH_PRIME};
  localparam logic [31:0] PRIME2_32 = {1'b0, HASH_PRIME, 1'b0};

  // Estimate the quotient from the top bits of the product
  assign quot_est = prod[59:29];
  assign quot     = quot_prod[61:31];

  // Remainder lies below three primes; pick the one in range
  assign rem_m1 = rem_raw - PRIME_32;
  assign rem_m2 = rem_raw - PRIME2_32;

  always_ff @(posedge clk) begin
    prod      <= {30'b0, a} * {30'b0, b};
    quot_prod <= {31'b0, quot_est} * {31'b0, BARRETT_M};
    prod_lo2  <= prod[31:0];
    // Only the low word of quotient times prime is needed
    qp_lo     <= {1'b0, quot} * PRIME_32;
    prod_lo3  <= prod_lo2;
    rem_raw   <= prod_lo3 - qp_lo;
    if (rem_raw >= PRIME2_32) begin
      rem <= rem_m2[29:0];
    end else if (rem_raw >= PRIME_32) begin
      rem <= rem_m1[29:0];
    end else begin
      rem <= rem_raw[29:0];
    end
  end

  assign r = rem;

endmodule

/* hdl/prefix_polynomial_hash_table.sv */
// ----------------------------------------------------------------------------
// prefix_polynomial_hash_table
// Prefix polynomial hashes of a byte string modulo 1000000007, with clear,
// append and substring-hash query operations.
// ----------------------------------------------------------------------------
// One word is handled at a time. An append or a query reaches the result
// register through the memory read at the accepting edge, the five stages
// of the Barrett modular multiplier, one finishing add and the hand-off
// state. A clear, an append to a full table, a zero-length query, a query
// starting past the string and the unused code pass only through the
// hand-off state, and the next word is accepted once the block is idle.
// A stalled result at the output keeps the next word in its hand-off state.
// A new word is accepted while the previous result still waits at the output.
// Prefix hashes and base powers sit in two synchronous memories of MAX_LEN+1
// entries; entry 0 is never written and reads as 0 (hashes) and 1 (powers),
// so no clearing pass follows reset. The hash base is reduced modulo the
// prime on write and should be written only while the block is idle.
// ----------------------------------------------------------------------------
module prefix_polynomial_hash_table #(
  parameter int MAX_LEN = pphash_pkg::DEF_MAX_LEN,
  parameter int LEN_W   = $clog2(MAX_LEN + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  // hash base register
  input  logic                          cfg_wr_en,
  input  logic [pphash_pkg::HASH_W-1:0] cfg_wr_data,
  // input words
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    func,
  input  logic [7:0]                    char_byte,
  input  logic [LEN_W-1:0]              start_pos,
  input  logic [LEN_W-1:0]              sub_length,
  // result words
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pphash_pkg::HASH_W-1:0] hash_value,
  output logic [1:0]                    status,
  output logic [LEN_W-1:0]              cur_length
);
  import pphash_pkg::*;

  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_LEN);
  localparam int               MUL_CNT_W = $clog2(MM_LAT - 1);
  localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(MM_LAT - 2);

  state_t state, state_next;

  // control registers
  logic [LEN_W-1:0]     stored_len;
  logic [29:0]          base_r;
  logic [MUL_CNT_W-1:0] mul_cnt;

  // per-word registers
  logic             op_append;
  logic [7:0]       char_r;
  logic [LEN_W-1:0] wr_addr;
  logic [29:0]      res_hash;
  status_t          res_status;

  // memories and read registers
  logic [29:0] prefix_mem [0:MAX_LEN];
  logic [29:0] power_mem  [0:MAX_LEN];
  logic [29:0] rd_pa, rd_pb, rd_pw;
  logic        za, zb, zw;

  // decode
  logic             in_accept;
  logic             go_read;
  logic             do_clear;
  status_t          imm_status;
  logic [LEN_W-1:0] span;
  logic [LEN_W-1:0] len_clip;
  logic [LEN_W-1:0] addr_a, addr_b, addr_w;
  logic             rd_en;
  logic             mem_we;
  logic             load_out;

  // datapath
  logic [29:0] base_in_red;
  logic [29:0] pa_val, pb_val, pw_val;
  logic [29:0] lane_a_y;
  logic [29:0] lane_a_r, lane_b_r;
  logic [30:0] sum_app, sum_qry, fin_sum, fin_sum_m;
  logic [29:0] fin_hash;

  // Next state, handshake and decode of the incoming word
  always_comb begin
    state_next = state;
    go_read    = 1'b0;
    do_clear   = 1'b0;
    imm_status = ST_OK;
    span       = stored_len - start_pos;
    len_clip   = (sub_length > span) ? span : sub_length;
    in_stall   = (state != S_IDLE);
    in_accept  = in_valid && (state == S_IDLE);
    load_out   = (state == S_DONE) && (!out_valid || !out_stall);

    unique case (func)
      FUNC_CLEAR: begin
        do_clear = 1'b1;
      end
      FUNC_APPEND: begin
        if (stored_len == LEN_MAX) begin
          imm_status = ST_FULL;
        end else begin
          go_read = 1'b1;
        end
      end
      FUNC_QUERY: begin
        if (sub_length == '0) begin
          imm_status = ST_OK;
        end else if (start_pos > stored_len) begin
          imm_status = ST_BEYOND;
        end else begin
          go_read = 1'b1;
        end
      end
      default: begin
        imm_status = ST_OK;
      end
    endcase

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = go_read ? S_READ : S_DONE;
        end
      end
      S_READ: state_next = S_MUL;
      S_MUL: begin
        if (mul_cnt == MUL_LAST) begin
          state_next = S_FIN;
        end
      end
      S_FIN: state_next = S_DONE;
      S_DONE: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Read addresses: last prefix for an append, both ends for a query
  assign addr_a = (func == FUNC_APPEND) ? stored_len : start_pos;
  assign addr_b = start_pos + len_clip;
  assign addr_w = (func == FUNC_APPEND) ? stored_len : len_clip;
  assign rd_en  = in_accept && go_read;
  assign mem_we = (state == S_FIN) && op_append;

  // Memory read and write-back
  always_ff @(posedge clk) begin
    if (mem_we) begin
      prefix_mem[wr_addr] <= fin_hash;
      power_mem[wr_addr]  <= lane_b_r;
    end
    if (rd_en) begin
      rd_pa <= prefix_mem[addr_a];
      rd_pb <= prefix_mem[addr_b];
      rd_pw <= power_mem[addr_w];
      za    <= (addr_a == '0);
      zb    <= (addr_b == '0);
      zw    <= (addr_w == '0);
    end
  end

  // Entry 0 holds fixed values
  assign pa_val = za ? 30'd0 : rd_pa;
  assign pb_val = zb ? 30'd0 : rd_pb;
  assign pw_val = zw ? 30'd1 : rd_pw;

  // Lane A: prefix times base (append) or prefix times power (query)
  assign lane_a_y = op_append ? base_r : pw_val;

  pphash_modmul u_mm_a (
    .clk (clk),
    .a   (pa_val),
    .b   (lane_a_y),
    .r   (lane_a_r)
  );

  // Lane B: next base power
  pphash_modmul u_mm_b (
    .clk (clk),
    .a   (pw_val),
    .b   (base_r),
    .r   (lane_b_r)
  );

  // Finish: add the byte, or subtract the scaled start prefix
  assign sum_app   = {1'b0, lane_a_r} + {23'b0, char_r};
  assign sum_qry   = {1'b0, pb_val} + {1'b0, HASH_PRIME} - {1'b0, lane_a_r};
  assign fin_sum   = op_append ? sum_app : sum_qry;
  assign fin_sum_m = fin_sum - {1'b0, HASH_PRIME};
  assign fin_hash  = (fin_sum >= {1'b0, HASH_PRIME}) ? fin_sum_m[29:0] : fin_sum[29:0];

  // Reduce the base once on write
  assign base_in_red = (cfg_wr_data >= HASH_PRIME) ? (cfg_wr_data - HASH_PRIME)
                                                   : cfg_wr_data;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stored_len <= '0;
      base_r     <= BASE_RESET;
      mul_cnt    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        base_r <= base_in_red;
      end
      if (in_accept && do_clear) begin
        stored_len <= '0;
      end else if (mem_we) begin
        stored_len <= wr_addr;
      end
      if (state == S_READ) begin
        mul_cnt <= '0;
      end else if (state == S_MUL) begin
        mul_cnt <= mul_cnt + MUL_CNT_W'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_stall == 1'b0) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Per-word payload and output register
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_append  <= go_read && (func == FUNC_APPEND);
      char_r     <= char_byte;
      wr_addr    <= stored_len + LEN_W'(1);
      res_hash   <= '0;
      res_status <= imm_status;
    end
    if (state == S_FIN) begin
      res_hash <= fin_hash;
    end
    if (load_out) begin
      hash_value <= res_hash;
      status     <= res_status;
      cur_length <= stored_len;
    end
  end

  // Base is always kept reduced
  a_base_reduced: assert property (@(posedge clk) disable iff (rst)
    base_r < HASH_PRIME)
    else $error("hash base register not reduced");

  // Both multiplier lanes deliver residues when the result is taken
  a_lanes_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |-> (lane_a_r < HASH_PRIME) && (lane_b_r < HASH_PRIME))
    else $error("modular multiplier result out of range");

  // Stored length stays within capacity
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    stored_len <= LEN_MAX)
    else $error("stored length beyond capacity");

  // Write-back never touches the fixed entry 0
  a_wr_entry: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (wr_addr != '0) && (wr_addr <= LEN_MAX))
    else $error("write-back address out of range");

  // Length changes only on a clear or an append write-back
  a_len_hold: assert property (@(posedge clk) disable iff (rst)
    (!in_accept && (state != S_FIN)) |=> $stable(stored_len))
    else $error("stored length changed outside an operation");

endmodule

/* verif/tb_prefix_polynomial_hash_table.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_prefix_polynomial_hash_table
// Self-checking bench for the prefix polynomial hash table. A scoreboard class
// keeps its own copy of the prefix hash and base power tables, predicts one
// result word per accepted input word, and checks the result stream in order.
// Directed words cover empty, clipped, zero-length and out-of-range queries,
// the unused code and a base change mid-string. Random phases under several
// bases, including a fill to capacity, follow with random idling and stalls.
// ----------------------------------------------------------------------------
module tb_prefix_polynomial_hash_table;
  import pphash_pkg::*;

  localparam int              MAX_LEN     = DEF_MAX_LEN;
  localparam int              LEN_W       = $clog2(MAX_LEN + 1);
  localparam longint unsigned PRIME       = 64'(HASH_PRIME);
  localparam logic [1:0]      FUNC_UNUSED = 2'd3;
  localparam int              SETTLE      = 12;
  localparam int              LONG_HOLD   = 300;
  localparam int              TIMEOUT_NS  = 3_000_000;

  typedef struct packed {
    logic [HASH_W-1:0] hash;
    status_t           st;
    logic [LEN_W-1:0]  len;
  } hash_result_t;

  // Track the string state and the result words it implies
  class hash_tracker;
    logic [HASH_W-1:0] prefix_tab [0:MAX_LEN];
    logic [HASH_W-1:0] power_tab  [0:MAX_LEN];
    int unsigned       str_len;
    logic [HASH_W-1:0] base_reg;
    hash_result_t      hashes_due [$];
    int unsigned       mismatches, results_checked;
    int unsigned       n_clear, n_append, n_full, n_query, n_beyond, n_unused;

    function new();
      foreach (prefix_tab[i]) begin
        prefix_tab[i] = '0;
        power_tab[i]  = '0;
      end
      power_tab[0] = HASH_W'(1);
      str_len      = 0;
      base_reg     = BASE_RESET;
    endfunction

    function void set_base(logic [HASH_W-1:0] v);
      base_reg = v;
    endfunction

    function int unsigned pending();
      return hashes_due.size();
    endfunction

    function logic [HASH_W-1:0] mulmod(logic [HASH_W-1:0] a, logic [HASH_W-1:0] b);
      longint unsigned p;
      p = ((a % PRIME) * (b % PRIME)) % PRIME;
      return HASH_W'(p);
    endfunction

    // Apply one accepted word and queue the result it produces
    function void note_word(logic [1:0] op, logic [7:0] chr,
                            logic [LEN_W-1:0] spos, logic [LEN_W-1:0] slen);
      int unsigned     n, s, l;
      longint unsigned h, whole, part;
      hash_result_t    r;
      n      = str_len;
      s      = 32'(spos);
      l      = 32'(slen);
      r.hash = '0;
      r.st   = ST_OK;
      case (op)
        FUNC_CLEAR: begin
          str_len = 0;
          n_clear++;
        end
        FUNC_APPEND: begin
          n_append++;
          if (n >= MAX_LEN) begin
            r.st = ST_FULL;
            n_full++;
          end else begin
            h = (longint'(mulmod(prefix_tab[n], base_reg)) + chr) % PRIME;
            prefix_tab[n + 1] = HASH_W'(h);
            power_tab[n + 1]  = mulmod(power_tab[n], base_reg);
            str_len           = n + 1;
            r.hash            = HASH_W'(h);
          end
        end
        FUNC_QUERY: begin
          n_query++;
          if (l == 0) begin
            r.hash = '0;
          end else if (s > n) begin
            r.st = ST_BEYOND;
            n_beyond++;
          end else begin
            // clip the substring to the end of the string
            if (l > n - s) l = n - s;
            whole  = longint'(prefix_tab[s + l]) % PRIME;
            part   = 64'(mulmod(prefix_tab[s], power_tab[l]));
            h      = (whole + PRIME - part) % PRIME;
            r.hash = HASH_W'(h);
          end
        end
        default: n_unused++;
      endcase
      r.len = LEN_W'(str_len);
      hashes_due = {hashes_due, r};
    endfunction

    // Compare one result word against the oldest prediction
    function void check_result(logic [HASH_W-1:0] act_hash, logic [1:0] act_st,
                               logic [LEN_W-1:0] act_len);
      hash_result_t e;
      results_checked++;
      if (hashes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result word: hash %0d status %0d length %0d",
                   $realtime, act_hash, act_st, act_len);
        return;
      end
      e = hashes_due.pop_front();
      if (act_hash !== e.hash || act_st !== e.st || act_len !== e.len) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result word %0d: expected hash %0d status %0d length %0d, %s %0d %0d %0d",
                   $realtime, results_checked, e.hash, e.st, e.len,
                   "got", act_hash, act_st, act_len);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en;
  logic [HASH_W-1:0]    cfg_wr_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           func;
  logic [7:0]           char_byte;
  logic [LEN_W-1:0]     start_pos;
  logic [LEN_W-1:0]     sub_length;
  logic                 out_valid;
  logic                 out_stall;
  logic [HASH_W-1:0]    hash_value;
  logic [1:0]           status;
  logic [LEN_W-1:0]     cur_length;

  hash_tracker tracker;
  bit          burst_mode;
  bit          long_hold_req;
  int unsigned base_writes;

  prefix_polynomial_hash_table #(.MAX_LEN(MAX_LEN)) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .char_byte   (char_byte),
    .start_pos   (start_pos),
    .sub_length  (sub_length),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hash_value  (hash_value),
    .status      (status),
    .cur_length  (cur_length)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a run that hangs
  initial begin
    #(TIMEOUT_NS);
    $display("Mismatches found");
    $finish;
  end

  // Offer one word after a random gap and hold it until accepted
  task automatic send_word(logic [1:0] op, logic [7:0] chr,
                           logic [LEN_W-1:0] spos, logic [LEN_W-1:0] slen);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    func       = op;
    char_byte  = chr;
    start_pos  = spos;
    sub_length = slen;
    in_valid   = 1'b1;
    do @(posedge clk); while (in_stall);
    tracker.note_word(op, chr, spos, slen);
  endtask

  task automatic send_append();
    send_word(FUNC_APPEND, 8'($urandom), LEN_W'($urandom), LEN_W'($urandom));
  endtask

  // Query inside the string: mostly in range, some zero-length, some overlong
  task automatic send_query_ok();
    int unsigned n, s, l, pick;
    n    = tracker.str_len;
    s    = $urandom_range(0, n);
    pick = $urandom_range(0, 99);
    if (pick < 8) l = 0;
    else if (pick < 22) l = $urandom_range(n - s + 1, 2047);
    else if (n > s) l = $urandom_range(1, n - s);
    else l = $urandom_range(1, 2047);
    send_word(FUNC_QUERY, 8'($urandom), LEN_W'(s), LEN_W'(l));
  endtask

  // Query that starts past the end of the string
  task automatic send_bad_query();
    int unsigned s, l;
    s = $urandom_range(tracker.str_len + 1, 2047);
    l = $urandom_range(1, 2047);
    send_word(FUNC_QUERY, 8'($urandom), LEN_W'(s), LEN_W'(l));
  endtask

  task automatic run_mixed(int count);
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) send_append();
      else if (pick < 83) send_query_ok();
      else if (pick < 93) send_bad_query();
      else if (pick < 97)
        send_word(FUNC_CLEAR, 8'($urandom), LEN_W'($urandom), LEN_W'($urandom));
      else
        send_word(FUNC_UNUSED, 8'($urandom), LEN_W'($urandom), LEN_W'($urandom));
    end
  endtask

  // Grow the string to capacity, then hit the full table and the far edges
  task automatic run_fill();
    while (tracker.str_len < MAX_LEN) begin
      if ($urandom_range(0, 9) != 0) send_append();
      else send_query_ok();
    end
    repeat (3) send_append();
    send_word(FUNC_QUERY, 8'h00, LEN_W'(0), LEN_W'(MAX_LEN));
    send_word(FUNC_QUERY, 8'h00, LEN_W'(MAX_LEN), LEN_W'(1));
    send_word(FUNC_QUERY, 8'h00, LEN_W'(MAX_LEN - 1), LEN_W'(2047));
    send_word(FUNC_QUERY, 8'h00, LEN_W'(MAX_LEN / 2), LEN_W'(MAX_LEN / 2));
    send_word(FUNC_QUERY, 8'h00, LEN_W'(MAX_LEN + 1), LEN_W'(1));
    repeat (6) send_query_ok();
  endtask

  // Stop offering and wait for every predicted result, plus pipeline slack
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_base(logic [HASH_W-1:0] v);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    tracker.set_base(v);
    base_writes++;
  endtask

  // Result side: random stalls, one long hold-off on request
  initial begin : result_sink
    int wait_n;
    out_stall = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall     = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
      end
      wait_n = burst_mode ? 0 : $urandom_range(0, 3);
      if (wait_n > 0) begin
        out_stall = 1'b1;
        repeat (wait_n) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      tracker.check_result(hash_value, status, cur_length);
    end
  end

  // Reset, directed words, then random phases under several bases
  initial begin : stimulus
    tracker       = new();
    burst_mode    = 1'b0;
    long_hold_req = 1'b0;
    base_writes   = 0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_valid      = 1'b0;
    func          = FUNC_CLEAR;
    char_byte     = '0;
    start_pos     = '0;
    sub_length    = '0;
    rst           = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty string: zero length, start past end, clip to nothing
    send_word(FUNC_QUERY,  8'h00, LEN_W'(0),    LEN_W'(0));
    send_word(FUNC_QUERY,  8'h00, LEN_W'(1),    LEN_W'(1));
    send_word(FUNC_QUERY,  8'h00, LEN_W'(0),    LEN_W'(2047));
    // byte extremes
    send_word(FUNC_APPEND, 8'h00, LEN_W'(0),    LEN_W'(0));
    send_word(FUNC_APPEND, 8'hFF, LEN_W'(0),    LEN_W'(0));
    send_word(FUNC_APPEND, 8'hA5, LEN_W'(0),    LEN_W'(0));
    send_word(FUNC_APPEND, 8'h5A, LEN_W'(0),    LEN_W'(0));
    // whole string, inner, overlong, start at end, start past end
    send_word(FUNC_QUERY,  8'h00, LEN_W'(0),    LEN_W'(4));
    send_word(FUNC_QUERY,  8'h00, LEN_W'(1),    LEN_W'(2));
    send_word(FUNC_QUERY,  8'h00, LEN_W'(0),    LEN_W'(2047));
    send_word(FUNC_QUERY,  8'h00, LEN_W'(4),    LEN_W'(3));
    send_word(FUNC_QUERY,  8'h00, LEN_W'(5),    LEN_W'(1));
    send_word(FUNC_QUERY,  8'h00, LEN_W'(1024), LEN_W'(0));
    send_word(FUNC_QUERY,  8'h00, LEN_W'(2047), LEN_W'(2047));
    // unused code, then clear and reuse
    send_word(FUNC_UNUSED, 8'hFF, LEN_W'(2047), LEN_W'(2047));
    send_word(FUNC_CLEAR,  8'h00, LEN_W'(0),    LEN_W'(0));
    send_word(FUNC_QUERY,  8'h00, LEN_W'(0),    LEN_W'(1));
    send_word(FUNC_APPEND, 8'h80, LEN_W'(0),    LEN_W'(0));
    send_word(FUNC_APPEND, 8'h7F, LEN_W'(0),    LEN_W'(0));
    // change the base mid-string, no clear
    drain();
    write_base(30'd1000000006);
    send_word(FUNC_APPEND, 8'h33, LEN_W'(0),    LEN_W'(0));
    send_word(FUNC_APPEND, 8'hCC, LEN_W'(0),    LEN_W'(0));
    send_word(FUNC_QUERY,  8'h00, LEN_W'(0),    LEN_W'(4));
    send_word(FUNC_QUERY,  8'h00, LEN_W'(1),    LEN_W'(3));

    // base 1, receiver holds off long enough to back up the input
    drain();
    write_base(30'd1);
    long_hold_req = 1'b1;
    send_word(FUNC_CLEAR, 8'h00, LEN_W'(0), LEN_W'(0));
    run_mixed(100);

    // largest residue base, keep the string, no idling on either side
    drain();
    write_base(30'd1000000006);
    burst_mode = 1'b1;
    run_mixed(100);
    burst_mode = 1'b0;

    // all-ones base, reduced modulo the prime
    drain();
    write_base(30'h3FFF_FFFF);
    send_word(FUNC_CLEAR, 8'h00, LEN_W'(0), LEN_W'(0));
    run_mixed(100);

    // base equal to the prime acts as zero
    drain();
    write_base(HASH_PRIME);
    send_word(FUNC_CLEAR, 8'h00, LEN_W'(0), LEN_W'(0));
    run_mixed(60);

    // random base, fill to capacity
    drain();
    write_base(HASH_W'($urandom_range(1, 1000000006)));
    send_word(FUNC_CLEAR, 8'h00, LEN_W'(0), LEN_W'(0));
    run_fill();

    // zero base
    drain();
    write_base('0);
    send_word(FUNC_CLEAR, 8'h00, LEN_W'(0), LEN_W'(0));
    run_mixed(60);

    drain();
    $display("Run covered %0d clears, %0d appends (%0d on a full table), %0d queries",
             tracker.n_clear, tracker.n_append, tracker.n_full, tracker.n_query);
    $display("  (%0d starting past the end), %0d unused codes, %0d bases, %0d results",
             tracker.n_beyond, tracker.n_unused, base_writes, tracker.results_checked);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
